// ===== rtl/multichannel_bouncing_step_generator_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the bouncing step generator
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_BOUNCING_STEP_GENERATOR_UNIT_MACROS_SVH
`define MULTICHANNEL_BOUNCING_STEP_GENERATOR_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Check that expr holds on every clock edge out of reset.
`define MBSG_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// Check that cons holds in the cycle after ante.
`define MBSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MBSG_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define MBSG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== rtl/mbsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsg_pkg
// Shared constants, item codes and control types of the step generator.
// ----------------------------------------------------------------------------
package mbsg_pkg;

  localparam int unsigned CHANNELS   = 8;
  localparam int unsigned OUT_W      = 8;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CHAN_W     = 3;
  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned POS_W      = 8;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [POS_W-1:0]      MAX_POS_RESET   = 8'd158;
  localparam logic [APB_ADDR_W-1:0] ADDR_BOUNCE_TOP = 3'd0;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK  = 2'd0,
    KIND_SET   = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  // Per-channel commands, already qualified by the pipeline advance.
  typedef struct packed {
    logic tick;
    logic load;
    logic clear;
  } ctrl_t;

endpackage

// ===== rtl/mbsg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsg_in_if / mbsg_out_if
// Valid/ready channels for command items and pin result items.
// ----------------------------------------------------------------------------
interface mbsg_in_if;
  logic                            valid;
  logic                            ready;
  logic [mbsg_pkg::KIND_W-1:0]     kind;
  logic [mbsg_pkg::CHAN_W-1:0]     channel;
  logic [mbsg_pkg::PERIOD_W-1:0]   period_value;

  modport source (output valid, kind, channel, period_value, input ready);
  modport sink   (input valid, kind, channel, period_value, output ready);
endinterface

interface mbsg_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbsg_pkg::OUT_W-1:0]  step_pins;
  logic [mbsg_pkg::OUT_W-1:0]  dir_pins;
  logic [mbsg_pkg::OUT_W-1:0]  stepped;

  modport source (output valid, step_pins, dir_pins, stepped, input ready);
  modport sink   (input valid, step_pins, dir_pins, stepped, output ready);
endinterface

// ===== rtl/multichannel_bouncing_step_generator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_bouncing_step_generator_unit
// Bank of stepper channels driven by tick, set-period and home commands.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | transaction contents
//  --------+-----+--------------------+------------------------------------
//  req_i   | in  | valid/ready        | kind, channel, period_value
//  rsp_o   | out | valid/ready        | step_pins, dir_pins, stepped
//  apb     | in  | psel/penable/pready| bounce top at byte address 0
//
//  One transaction per cycle sustained while the result side is ready; a
//  command is registered, then all channels update in parallel on the way
//  into the result register.
//  Reset clears every channel and loads the bounce top with 158.
//  A stalled result holds in its register while one more command waits in
//  the input register; request ready drops only when both are full.
`include "multichannel_bouncing_step_generator_unit_macros.svh"

module multichannel_bouncing_step_generator_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mbsg_in_if.sink                          req_i,
  mbsg_out_if.source                       rsp_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbsg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mbsg_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [mbsg_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  // Configuration register.
  logic [mbsg_pkg::POS_W-1:0] max_pos_q;

  assign pready = 1'b1;
  assign prdata = (paddr == mbsg_pkg::ADDR_BOUNCE_TOP)
                ? mbsg_pkg::APB_DATA_W'(max_pos_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pos_q <= mbsg_pkg::MAX_POS_RESET;
    end else if (psel && penable && pwrite && (paddr == mbsg_pkg::ADDR_BOUNCE_TOP)) begin
      max_pos_q <= pwdata[mbsg_pkg::POS_W-1:0];
    end
  end

  // Input register: capture a command whenever the slot is free or drains.
  logic                            s1_v_q;
  logic [mbsg_pkg::KIND_W-1:0]     s1_kind_q;
  logic [mbsg_pkg::CHAN_W-1:0]     s1_chan_q;
  logic [mbsg_pkg::PERIOD_W-1:0]   s1_period_q;
  logic                            out_v_q;
  logic                            adv;

  // Move the held command into the result register when it has room.
  assign adv         = s1_v_q && (!out_v_q || rsp_o.ready);
  assign req_i.ready = !s1_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_kind_q   <= req_i.kind;
      s1_chan_q   <= req_i.channel;
      s1_period_q <= req_i.period_value;
    end
  end

  // Decode once; an undefined kind drives no command and just reports pins.
  logic is_tick, is_set, is_clear;
  assign is_tick  = adv && (s1_kind_q == mbsg_pkg::KIND_TICK);
  assign is_set   = adv && (s1_kind_q == mbsg_pkg::KIND_SET);
  assign is_clear = adv && (s1_kind_q == mbsg_pkg::KIND_CLEAR);

  logic [mbsg_pkg::CHANNELS-1:0] pin_d, dir_d, hit;

  for (genvar i = 0; i < mbsg_pkg::CHANNELS; i++) begin : g_chan
    mbsg_pkg::ctrl_t ctrl;
    assign ctrl.tick  = is_tick;
    assign ctrl.load  = is_set && (32'(s1_chan_q) == 32'(i));
    assign ctrl.clear = is_clear;

    mbsg_channel u_chan (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .period_value_i (s1_period_q),
      .bounce_top_i   (max_pos_q),
      .step_pin_d_o   (pin_d[i]),
      .dir_d_o        (dir_d[i]),
      .hit_o          (hit[i])
    );
  end

  // Fit the channel bank onto the fixed-width pin fields; extra channels
  // run but stay invisible, missing ones read as zero.
  logic [mbsg_pkg::OUT_W-1:0] step_w, dir_w, hit_w;
  for (genvar j = 0; j < mbsg_pkg::OUT_W; j++) begin : g_pin
    if (j < mbsg_pkg::CHANNELS) begin : g_on
      assign step_w[j] = pin_d[j];
      assign dir_w[j]  = dir_d[j];
      assign hit_w[j]  = hit[j];
    end else begin : g_off
      assign step_w[j] = 1'b0;
      assign dir_w[j]  = 1'b0;
      assign hit_w[j]  = 1'b0;
    end
  end

  // Result register.
  logic [mbsg_pkg::OUT_W-1:0] out_step_q, out_dir_q, out_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_step_q <= step_w;
      out_dir_q  <= dir_w;
      out_hit_q  <= hit_w;
    end
  end

  assign rsp_o.valid     = out_v_q;
  assign rsp_o.step_pins = out_step_q;
  assign rsp_o.dir_pins  = out_dir_q;
  assign rsp_o.stepped   = out_hit_q;

  // Only a tick can report steps.
  `MBSG_ASSERT_NEXT(a_step_only_on_tick, clk_i, rst_ni, adv && !is_tick,
                    out_hit_q == '0, "step reported for a non-tick command")
  // Homing drives every pin low and every direction forward.
  `MBSG_ASSERT_NEXT(a_home_clears_pins, clk_i, rst_ni, is_clear,
                    (out_step_q == '0) && (out_dir_q == '0), "home left pins set")
  // A result appears only from a command that moved out of the input register.
  `MBSG_ASSERT_ALWAYS(a_result_from_adv, clk_i, rst_ni, !$rose(out_v_q) || $past(adv),
                      "result valid without a command")

endmodule

// ===== rtl/mbsg_channel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsg_channel
// One stepper channel: period, tick counter, bouncing head and step level.
// ----------------------------------------------------------------------------
module mbsg_channel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mbsg_pkg::ctrl_t               ctrl_i,
  input  logic [mbsg_pkg::PERIOD_W-1:0] period_value_i,
  input  logic [mbsg_pkg::POS_W-1:0]    bounce_top_i,
  output logic                          step_pin_d_o,
  output logic                          dir_d_o,
  output logic                          hit_o
);

  logic [mbsg_pkg::PERIOD_W-1:0] period_q, period_d;
  logic [mbsg_pkg::PERIOD_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic [mbsg_pkg::POS_W-1:0]    pos_q, pos_d, pos_step;
  logic                          dir_q, dir_d, dir_new;
  logic                          lvl_q, lvl_d;
  logic                          pin_q, pin_d;
  logic                          active;
  logic                          hit;

  assign active  = ctrl_i.tick && (period_q != '0);
  assign cnt_inc = cnt_q + mbsg_pkg::PERIOD_W'(1);
  assign hit     = active && (cnt_inc >= period_q);

  // Bounce: reverse at the top, turn forward at home, else keep going.
  always_comb begin
    if (pos_q >= bounce_top_i) begin
      dir_new = 1'b1;
    end else if (pos_q == '0) begin
      dir_new = 1'b0;
    end else begin
      dir_new = dir_q;
    end
    pos_step = dir_new ? (pos_q - mbsg_pkg::POS_W'(1)) : (pos_q + mbsg_pkg::POS_W'(1));
  end

  always_comb begin
    period_d = period_q;
    cnt_d    = cnt_q;
    pos_d    = pos_q;
    dir_d    = dir_q;
    lvl_d    = lvl_q;
    pin_d    = pin_q;
    if (active) begin
      cnt_d = hit ? '0 : cnt_inc;
    end
    if (hit) begin
      pos_d = pos_step;
      dir_d = dir_new;
      pin_d = lvl_q;
      lvl_d = ~lvl_q;
    end
    if (ctrl_i.load) begin
      period_d = period_value_i;
    end
    // Home: the counter and the level survive.
    if (ctrl_i.clear) begin
      period_d = '0;
      pos_d    = '0;
      dir_d    = 1'b0;
      pin_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
      cnt_q    <= '0;
      pos_q    <= '0;
      dir_q    <= 1'b0;
      lvl_q    <= 1'b0;
      pin_q    <= 1'b0;
    end else begin
      period_q <= period_d;
      cnt_q    <= cnt_d;
      pos_q    <= pos_d;
      dir_q    <= dir_d;
      lvl_q    <= lvl_d;
      pin_q    <= pin_d;
    end
  end

  assign step_pin_d_o = pin_d;
  assign dir_d_o      = dir_d;
  assign hit_o        = hit;

endmodule

// ===== verif/mbsg_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbsg_scoreboard
// Watches the command, result and APB ports of the step generator, predicts
// the pin state of every channel and compares each result transaction.
// ----------------------------------------------------------------------------
module mbsg_scoreboard (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mbsg_in_if                               req_i,
  mbsg_out_if                              rsp_i,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mbsg_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [mbsg_pkg::APB_DATA_W-1:0]  pwdata,
  input  logic [mbsg_pkg::APB_DATA_W-1:0]  prdata,
  input  logic                             pready,
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);

  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [mbsg_pkg::OUT_W-1:0] step_pins;
    logic [mbsg_pkg::OUT_W-1:0] dir_pins;
    logic [mbsg_pkg::OUT_W-1:0] stepped;
  } pin_result_t;

  // Shadow copy of the channel bank.
  logic [mbsg_pkg::POS_W-1:0]    max_pos_q;
  logic [mbsg_pkg::PERIOD_W-1:0] period_q  [mbsg_pkg::CHANNELS];
  logic [mbsg_pkg::PERIOD_W-1:0] count_q   [mbsg_pkg::CHANNELS];
  logic [mbsg_pkg::POS_W-1:0]    pos_q     [mbsg_pkg::CHANNELS];
  logic                          reverse_q [mbsg_pkg::CHANNELS];
  logic                          level_q   [mbsg_pkg::CHANNELS];
  logic                          pin_q     [mbsg_pkg::CHANNELS];

  pin_result_t expected_pins [$];

  task automatic flag_error(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_LIMIT) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Apply one command to the shadow bank and return the pins it leaves.
  function automatic pin_result_t predict_pins(
    input logic [mbsg_pkg::KIND_W-1:0]   kind,
    input logic [mbsg_pkg::CHAN_W-1:0]   chan,
    input logic [mbsg_pkg::PERIOD_W-1:0] pval
  );
    pin_result_t res;
    res = '0;
    case (kind)
      mbsg_pkg::KIND_TICK: begin
        for (int c = 0; c < mbsg_pkg::CHANNELS; c++) begin
          if (period_q[c] != '0) begin
            count_q[c] = count_q[c] + 1'b1;
            if (count_q[c] >= period_q[c]) begin
              // Bounce off the top, turn forward at home.
              if (pos_q[c] >= max_pos_q) begin
                reverse_q[c] = 1'b1;
              end else if (pos_q[c] == '0) begin
                reverse_q[c] = 1'b0;
              end
              pos_q[c]       = reverse_q[c] ? pos_q[c] - 1'b1 : pos_q[c] + 1'b1;
              pin_q[c]       = level_q[c];
              level_q[c]     = ~level_q[c];
              count_q[c]     = '0;
              res.stepped[c] = 1'b1;
            end
          end
        end
      end
      mbsg_pkg::KIND_SET: begin
        if (chan < mbsg_pkg::CHANNELS) begin
          period_q[chan] = pval;
        end
      end
      mbsg_pkg::KIND_CLEAR: begin
        // Home all channels; counters and stored levels survive.
        for (int c = 0; c < mbsg_pkg::CHANNELS; c++) begin
          period_q[c]  = '0;
          pos_q[c]     = '0;
          reverse_q[c] = 1'b0;
          pin_q[c]     = 1'b0;
        end
      end
      default: ;
    endcase
    for (int c = 0; c < mbsg_pkg::CHANNELS; c++) begin
      res.step_pins[c] = pin_q[c];
      res.dir_pins[c]  = reverse_q[c];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    pin_result_t got;
    pin_result_t want;
    if (!rst_ni) begin
      max_pos_q = mbsg_pkg::MAX_POS_RESET;
      for (int c = 0; c < mbsg_pkg::CHANNELS; c++) begin
        period_q[c]  = '0;
        count_q[c]   = '0;
        pos_q[c]     = '0;
        reverse_q[c] = 1'b0;
        level_q[c]   = 1'b0;
        pin_q[c]     = 1'b0;
      end
      expected_pins.delete();
      pending_o = 0;
    end else begin
      // Check results before queuing this edge's command.
      if (rsp_i.valid && rsp_i.ready) begin
        got = '{step_pins: rsp_i.step_pins, dir_pins: rsp_i.dir_pins,
                stepped: rsp_i.stepped};
        if (expected_pins.size() == 0) begin
          flag_error($sformatf("result with nothing expected: step %h dir %h stepped %h",
                               got.step_pins, got.dir_pins, got.stepped));
        end else begin
          want = expected_pins.pop_front();
          if (got !== want) begin
            flag_error($sformatf({"result mismatch: step exp %h got %h, ",
                                  "dir exp %h got %h, stepped exp %h got %h"},
                                 want.step_pins, got.step_pins, want.dir_pins,
                                 got.dir_pins, want.stepped, got.stepped));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_pins.push_back(predict_pins(req_i.kind, req_i.channel,
                                             req_i.period_value));
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == mbsg_pkg::ADDR_BOUNCE_TOP) begin
            max_pos_q = pwdata[mbsg_pkg::POS_W-1:0];
          end
        end else if (prdata !== mbsg_pkg::APB_DATA_W'(max_pos_q)) begin
          flag_error($sformatf("bounce top readback exp %h got %h",
                               mbsg_pkg::APB_DATA_W'(max_pos_q), prdata));
        end
      end
      pending_o = expected_pins.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives commands, result back-pressure and bounce top writes into the
// step generator; the scoreboard beside it predicts and checks every result.
// ----------------------------------------------------------------------------
module tb_top;

  // Command code the block treats as a no-op.
  localparam logic [mbsg_pkg::KIND_W-1:0] KIND_UNDEF = 2'd3;

  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 104;
  localparam int unsigned RANDOM_PHASE  = 4;
  localparam int unsigned HOLD_CYCLES   = 150;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [mbsg_pkg::APB_ADDR_W-1:0] paddr;
  logic [mbsg_pkg::APB_DATA_W-1:0] pwdata;
  logic [mbsg_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  mbsg_in_if  req_if ();
  mbsg_out_if rsp_if ();

  // Idle odds out of a hundred, set per phase by the stimulus process.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Long back-pressure requests; the stimulus raises, the receiver serves.
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;

  int unsigned fail_count;
  int unsigned pending_count;

  always #5 clk_i = ~clk_i;

  multichannel_bouncing_step_generator_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_if),
    .rsp_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mbsg_scoreboard u_scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending_count)
  );

  // Offer one command transaction and hold it until the block takes it.
  // Random idle cycles drop valid first; a back-to-back item keeps valid high
  // and only swaps the payload.
  task automatic send_item(input logic [mbsg_pkg::KIND_W-1:0]   kind,
                           input logic [mbsg_pkg::CHAN_W-1:0]   chan,
                           input logic [mbsg_pkg::PERIOD_W-1:0] pval);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.kind         <= kind;
    req_if.channel      <= chan;
    req_if.period_value <= pval;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Stop offering and wait for every outstanding result. Sample the
  // scoreboard count on the falling edge, clear of its update.
  task automatic drain;
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
  endtask

  // Run one APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic                            write,
                            input logic [mbsg_pkg::APB_ADDR_W-1:0] addr,
                            input logic [mbsg_pkg::APB_DATA_W-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reprogram the bounce top with the block idle, then read it back.
  // Upper data bits carry noise; the register keeps the low byte only.
  task automatic set_bounce_top(input logic [mbsg_pkg::POS_W-1:0] value);
    logic [mbsg_pkg::APB_DATA_W-1:0] data;
    data                     = $urandom();
    data[mbsg_pkg::POS_W-1:0] = value;
    drain();
    apb_access(1'b1, mbsg_pkg::ADDR_BOUNCE_TOP, data);
    apb_access(1'b0, mbsg_pkg::ADDR_BOUNCE_TOP, '0);
  endtask

  // Result side: random stalls, plus a long hold-off on request so that
  // the result register and the input register both fill up.
  initial begin : rsp_drive
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_requests != holds_served) begin
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_served++;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int unsigned                   roll;
    int unsigned                   shape;
    logic [mbsg_pkg::KIND_W-1:0]   kind;
    logic [mbsg_pkg::CHAN_W-1:0]   chan;
    logic [mbsg_pkg::PERIOD_W-1:0] pval;
    logic [mbsg_pkg::POS_W-1:0]    new_max;

    // Every input known from time zero, with reset asserted.
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.kind         <= mbsg_pkg::KIND_TICK;
    req_if.channel      <= '0;
    req_if.period_value <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Check the reset value of the bounce top.
    apb_access(1'b0, mbsg_pkg::ADDR_BOUNCE_TOP, '0);

    // ---- Directed part, no idling, bounce top at its reset value ----
    // Fastest, slow and slowest periods.
    send_item(mbsg_pkg::KIND_SET, 3'd0, 16'd1);
    send_item(mbsg_pkg::KIND_SET, 3'd1, 16'd2);
    send_item(mbsg_pkg::KIND_SET, 3'd7, 16'hFFFF);
    send_item(mbsg_pkg::KIND_TICK, 3'd0, 16'd0);
    send_item(mbsg_pkg::KIND_TICK, 3'd7, 16'hFFFF);
    send_item(mbsg_pkg::KIND_TICK, 3'd0, 16'd0);
    // Lower a period below the running count: next tick must step.
    send_item(mbsg_pkg::KIND_SET, 3'd4, 16'd10);
    repeat (5) send_item(mbsg_pkg::KIND_TICK, 3'd0, 16'd0);
    send_item(mbsg_pkg::KIND_SET, 3'd4, 16'd2);
    send_item(mbsg_pkg::KIND_TICK, 3'd0, 16'd0);
    // Undefined command reports the pins unchanged.
    send_item(KIND_UNDEF, 3'd7, 16'h5555);
    // Zero period silences a channel.
    send_item(mbsg_pkg::KIND_SET, 3'd3, 16'd0);
    send_item(mbsg_pkg::KIND_SET, 3'd6, 16'd1);
    send_item(mbsg_pkg::KIND_TICK, 3'd5, 16'hAAAA);
    // Home everything: pins low, counters and levels kept.
    send_item(mbsg_pkg::KIND_CLEAR, 3'd5, 16'hFFFF);
    send_item(mbsg_pkg::KIND_TICK, 3'd0, 16'd0);
    send_item(mbsg_pkg::KIND_SET, 3'd2, 16'd1);
    send_item(mbsg_pkg::KIND_TICK, 3'd0, 16'd0);
    // Zero bounce top: always reverse, wrap from home to 255.
    set_bounce_top(8'd0);
    repeat (3) send_item(mbsg_pkg::KIND_TICK, 3'd0, 16'd0);

    // ---- Random phases: one bounce top and one idling mix each ----
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:            new_max = 8'd1;
        1:            new_max = 8'd255;
        2:            new_max = 8'd0;
        3:            new_max = 8'd4;
        RANDOM_PHASE: new_max = mbsg_pkg::POS_W'($urandom_range(1, 255));
        default:      new_max = mbsg_pkg::MAX_POS_RESET;
      endcase
      set_bounce_top(new_max);
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // Fill the block once: the receiver holds off while we keep sending.
      if (p == 0) begin
        hold_requests++;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(99);
        chan = mbsg_pkg::CHAN_W'($urandom_range(0, mbsg_pkg::CHANNELS - 1));
        pval = mbsg_pkg::PERIOD_W'($urandom());
        // Mostly ticks with short periods, so heads actually bounce;
        // homing stays rare to let positions build up.
        if (roll < 70) begin
          kind = mbsg_pkg::KIND_TICK;
        end else if (roll < 90) begin
          kind  = mbsg_pkg::KIND_SET;
          shape = $urandom_range(9);
          if (shape < 6) begin
            pval = mbsg_pkg::PERIOD_W'($urandom_range(1, 4));
          end else if (shape < 7) begin
            pval = '0;
          end else if (shape < 8) begin
            pval = mbsg_pkg::PERIOD_W'($urandom_range(5, 40));
          end
        end else if (roll < 94) begin
          kind = mbsg_pkg::KIND_CLEAR;
        end else begin
          kind = KIND_UNDEF;
        end
        send_item(kind, chan, pval);
      end
    end

    // ---- Wind down ----
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: a stuck handshake or a lost result ends here.
  initial begin : watchdog
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
